FILE: rtl/core/vfe_pkg.sv
package vfe_pkg;

  localparam int NumDirs      = 6;
  localparam int VertsPerFace = 6;

  // one input word: a voxel cell
  typedef struct packed {
    logic [5:0] local_x;
    logic [5:0] local_y;
    logic [7:0] local_z;
    logic [7:0] material;
    logic [5:0] face_mask;
  } vfe_in_t;

  // one output word: a vertex
  typedef struct packed {
    logic [19:0] vertex_word;
    logic [10:0] face_word;
    logic        last;
  } vfe_out_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } vfe_state_t;

  // sequencer -> vertex unit
  typedef struct packed {
    logic       emit;
    logic [2:0] dir;
    logic [2:0] vert;
    logic       last;
  } vfe_ctl_t;

  // corner offsets {cx, cy, cz}, two triangles per face
  localparam logic [2:0] CORNER_TAB [NumDirs][VertsPerFace] = '{
    '{3'b100, 3'b110, 3'b111, 3'b100, 3'b111, 3'b101},  // +X
    '{3'b010, 3'b000, 3'b001, 3'b010, 3'b001, 3'b011},  // -X
    '{3'b110, 3'b010, 3'b011, 3'b110, 3'b011, 3'b111},  // +Y
    '{3'b000, 3'b100, 3'b101, 3'b000, 3'b101, 3'b001},  // -Y
    '{3'b001, 3'b101, 3'b111, 3'b001, 3'b111, 3'b011},  // +Z
    '{3'b010, 3'b110, 3'b100, 3'b010, 3'b100, 3'b000}   // -Z
  };

  function automatic logic [2:0] corner(input logic [2:0] dir, input logic [2:0] vert);
    corner = CORNER_TAB[dir][vert];
  endfunction

endpackage

FILE: rtl/core/vfe_seq.sv
module vfe_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        material,
  input  logic [5:0]        face_mask,
  input  logic              slot_free,
  output vfe_pkg::vfe_ctl_t ctl
);

  localparam logic [2:0] LastVert = 3'(vfe_pkg::VertsPerFace - 1);

  vfe_pkg::vfe_state_t state_r, state_nxt;
  logic [5:0] pend_r, pend_nxt;
  logic [2:0] dir_r, dir_nxt;
  logic [2:0] vert_r, vert_nxt;

  logic       accept;
  logic       start;
  logic       face_on;
  logic       face_done;
  logic [5:0] dir_hot;
  logic [5:0] remain;

  assign in_ready  = (state_r == vfe_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign start     = accept && (material != 8'd0) && (face_mask != 6'd0);
  assign face_on   = pend_r[dir_r];
  assign dir_hot   = 6'd1 << dir_r;
  assign remain    = pend_r & ~dir_hot;
  assign face_done = face_on && slot_free && (vert_r == LastVert);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vfe_pkg::ST_IDLE: begin
        if (start) state_nxt = vfe_pkg::ST_RUN;
      end
      vfe_pkg::ST_RUN: begin
        if (face_done && remain == 6'd0) state_nxt = vfe_pkg::ST_IDLE;
      end
      default: state_nxt = vfe_pkg::ST_IDLE;
    endcase
  end

  // counters and control to the vertex unit
  always_comb begin
    pend_nxt = pend_r;
    dir_nxt  = dir_r;
    vert_nxt = vert_r;
    ctl      = '0;
    unique case (state_r)
      vfe_pkg::ST_IDLE: begin
        if (start) begin
          pend_nxt = face_mask;
          dir_nxt  = 3'd0;
          vert_nxt = 3'd0;
        end
      end
      vfe_pkg::ST_RUN: begin
        if (!face_on) begin
          dir_nxt = dir_r + 3'd1;  // skip hidden face
        end else if (slot_free) begin
          ctl.emit = 1'b1;
          ctl.dir  = dir_r;
          ctl.vert = vert_r;
          ctl.last = (vert_r == LastVert) && (remain == 6'd0);
          if (vert_r == LastVert) begin
            vert_nxt = 3'd0;
            pend_nxt = remain;
            dir_nxt  = dir_r + 3'd1;
          end else begin
            vert_nxt = vert_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfe_pkg::ST_IDLE;
      pend_r  <= '0;
      dir_r   <= '0;
      vert_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      dir_r   <= dir_nxt;
      vert_r  <= vert_nxt;
    end
  end

endmodule

FILE: rtl/core/vfe_vtx.sv
module vfe_vtx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  vfe_pkg::vfe_in_t  item,
  input  vfe_pkg::vfe_ctl_t ctl,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output vfe_pkg::vfe_out_t out_data
);

  vfe_pkg::vfe_in_t  item_r;
  vfe_pkg::vfe_out_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        cnr;

  assign slot_free = !out_valid_r || out_ready;
  assign cnr       = vfe_pkg::corner(ctl.dir, ctl.vert);

  // shared corner adder: one vertex per cycle while the output slot is free
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctl.emit) begin
      out_nxt.vertex_word = {item_r.local_z + 8'(cnr[0]),
                             item_r.local_y + 6'(cnr[1]),
                             item_r.local_x + 6'(cnr[2])};
      out_nxt.face_word   = {ctl.dir, item_r.material};
      out_nxt.last        = ctl.last;
      out_valid_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (load) item_r <= item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/voxel_face_vertex_emitter.sv
// Voxel face vertex emitter.
// Input channel in_valid/in_ready/in_data: one word per voxel cell (coords,
// block type, visible-face mask). Output channel out_valid/out_ready/out_data:
// one word per vertex, six per visible face, faces in order +X -X +Y -Y +Z -Z;
// the final vertex of a cell has last set.
// An empty cell (block type 0) or a zero mask produces nothing and the block
// stays ready for the next word.
// in_ready is high only while the sequencer is idle: one cell at a time.
// The first vertex is registered in the output register and shows on out_valid
// after the input word is taken, once the sequencer has stepped past each
// hidden direction before the first visible one. Vertices then leave one per
// cycle from the shared corner adder while the receiver takes them, with a gap
// for each hidden direction below the highest visible one.
// A stalled receiver holds the output register; the sequencer waits on it and
// loses nothing.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; the block keeps no state across cells.
module voxel_face_vertex_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vfe_pkg::vfe_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vfe_pkg::vfe_out_t out_data
);

  vfe_pkg::vfe_ctl_t ctl;
  logic              slot_free;
  logic              load;

  // capture the cell on every accepted word; empty cells just don't start
  assign load = in_valid && in_ready;

  vfe_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .material   (in_data.material),
    .face_mask  (in_data.face_mask),
    .slot_free  (slot_free),
    .ctl        (ctl)
  );

  vfe_vtx u_vtx (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .item      (in_data),
    .ctl       (ctl),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/vfe_chk.sv
module vfe_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input vfe_pkg::vfe_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input vfe_pkg::vfe_out_t out_data
);

  // waiting input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while waiting");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  // mid-cell vertex pending means no new cell taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("ready while cell unfinished");

  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.face_word[10:8] != 3'd6) && (out_data.face_word[10:8] != 3'd7))
    else $error("bad face direction");

  a_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.face_word[7:0] != 8'd0)
    else $error("vertex for empty cell");

endmodule

bind voxel_face_vertex_emitter vfe_chk u_vfe_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
